// ===== sv/mwma_pkg.sv =====
// ----------------------------------------------------------------------------
// mwma_pkg
// Shared constants and types of the multi-window moving average: window
// lengths, datapath widths, reciprocal constants and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mwma_pkg;

  localparam int NUM_WIN        = 4;
  localparam int WINDOW_SHORT   = 5;
  localparam int WINDOW_MEDIUM  = 20;
  localparam int WINDOW_LONG    = 60;
  localparam int WINDOW_LONGEST = 200;

  localparam int WIN_MAX_A = (WINDOW_SHORT > WINDOW_MEDIUM) ? WINDOW_SHORT : WINDOW_MEDIUM;
  localparam int WIN_MAX_B = (WINDOW_LONG > WINDOW_LONGEST) ? WINDOW_LONG : WINDOW_LONGEST;
  localparam int WIN_MAX   = (WIN_MAX_A > WIN_MAX_B) ? WIN_MAX_A : WIN_MAX_B;

  localparam int WIN_LEN [NUM_WIN] = '{WINDOW_SHORT, WINDOW_MEDIUM, WINDOW_LONG, WINDOW_LONGEST};

  localparam int PRICE_W = 32;
  localparam int SUM_W   = 40;
  localparam int FRAC_W  = 8;
  localparam int AVG_W   = 40;
  localparam int BARS_W  = $clog2(WIN_MAX + 1);

  // long division of sum*256 by the window, one 16-bit digit per step
  localparam int DIV_W       = SUM_W + FRAC_W;
  localparam int DIGIT_W     = 16;
  localparam int NUM_DIGITS  = DIV_W / DIGIT_W;
  localparam int NUM_STAGES  = 2 * NUM_DIGITS;
  localparam int REM_W       = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam int T_W         = REM_W + DIGIT_W;
  localparam int RECIP_SHIFT = T_W + REM_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = T_W + RECIP_W;

  // ceil(2^RECIP_SHIFT / W): exact quotient for any partial dividend below W*2^DIGIT_W
  localparam logic [RECIP_W-1:0] WIN_RECIP [NUM_WIN] = '{
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW_SHORT) - 64'd1) / 64'(WINDOW_SHORT)),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW_MEDIUM) - 64'd1) / 64'(WINDOW_MEDIUM)),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LONG) - 64'd1) / 64'(WINDOW_LONG)),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LONGEST) - 64'd1) / 64'(WINDOW_LONGEST))
  };

  typedef logic [SUM_W-1:0] sum_t;

  // running sums after one word, with window-full flags
  typedef struct packed {
    logic [NUM_WIN-1:0]            full;
    logic [NUM_WIN-1:0][SUM_W-1:0] sum;
  } snap_t;

  // one divider lane in flight
  typedef struct packed {
    logic             full;
    logic [SUM_W-1:0] sum;
    logic [T_W-1:0]   t;
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] quo;
  } lane_t;

  // divider result
  typedef struct packed {
    logic [NUM_WIN-1:0]            full;
    logic [NUM_WIN-1:0][DIV_W-1:0] quo;
  } quot_t;

endpackage

`default_nettype wire

// ===== sv/mwma_history.sv =====
// ----------------------------------------------------------------------------
// mwma_history
// Price shift line, bar count and running window sums. Updates on each
// accepted word and registers a snapshot of the sums for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mwma_history import mwma_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PRICE_W-1:0] in_price,
  input  logic               in_new_bar,
  output logic               snap_valid,
  input  logic               snap_ready,
  output snap_t              snap
);

  logic [PRICE_W-1:0] hist_r   [WIN_MAX];
  logic [PRICE_W-1:0] hist_nxt [WIN_MAX];
  logic [BARS_W-1:0]  bars_r, bars_nxt;
  sum_t               sum_r   [NUM_WIN];
  sum_t               sum_nxt [NUM_WIN];
  logic               snap_valid_r;
  snap_t              snap_r, snap_nxt;
  logic               acc;
  logic               ignore_rep;

  assign in_ready   = !snap_valid_r || snap_ready;
  assign acc        = in_valid && in_ready;
  // revision with nothing held: no change, all windows invalid
  assign ignore_rep = !in_new_bar && (bars_r == '0);

  always_comb begin
    logic [PRICE_W-1:0] sub;
    hist_nxt = hist_r;
    bars_nxt = bars_r;
    sum_nxt  = sum_r;
    sub      = '0;
    if (in_new_bar) begin
      hist_nxt[0] = in_price;
      for (int i = 1; i < WIN_MAX; i++) begin
        hist_nxt[i] = hist_r[i-1];
      end
      if (bars_r < BARS_W'(WIN_MAX)) begin
        bars_nxt = bars_r + 1'b1;
      end
      for (int k = 0; k < NUM_WIN; k++) begin
        sub = (bars_r >= BARS_W'(WIN_LEN[k])) ? hist_r[WIN_LEN[k]-1] : '0;
        sum_nxt[k] = sum_r[k] + SUM_W'(in_price) - SUM_W'(sub);
      end
    end else if (!ignore_rep) begin
      hist_nxt[0] = in_price;
      for (int k = 0; k < NUM_WIN; k++) begin
        sum_nxt[k] = sum_r[k] + SUM_W'(in_price) - SUM_W'(hist_r[0]);
      end
    end
    for (int k = 0; k < NUM_WIN; k++) begin
      snap_nxt.full[k] = (bars_nxt >= BARS_W'(WIN_LEN[k]));
      snap_nxt.sum[k]  = sum_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bars_r       <= '0;
      snap_valid_r <= 1'b0;
      for (int k = 0; k < NUM_WIN; k++) begin
        sum_r[k] <= '0;
      end
    end else begin
      if (acc) begin
        bars_r <= bars_nxt;
        sum_r  <= sum_nxt;
      end
      if (in_ready) begin
        snap_valid_r <= in_valid;
      end
    end
  end

  // history line and snapshot: payload only
  always_ff @(posedge clk) begin
    if (acc) begin
      hist_r <= hist_nxt;
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

  a_bars_step: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_new_bar && (bars_r < BARS_W'(WIN_MAX))) |=> (bars_r == $past(bars_r) + 1'b1))
    else $error("bar count did not advance on a new bar");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (bars_r == '0) |-> (sum_r[NUM_WIN-1] == '0))
    else $error("running sum non-zero with no bars held");

endmodule

`default_nettype wire

// ===== sv/mwma_divider.sv =====
// ----------------------------------------------------------------------------
// mwma_divider
// Four-lane pipelined division of sum*256 by the fixed window lengths.
// Each 16-bit digit takes a reciprocal-multiply stage and a remainder stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mwma_divider import mwma_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  snap_t in_snap,
  output logic  out_valid,
  input  logic  out_ready,
  output quot_t out_quot
);

  lane_t                 stage_r   [NUM_STAGES][NUM_WIN];
  lane_t                 stage_nxt [NUM_STAGES][NUM_WIN];
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_up;
  logic [NUM_STAGES:0]   load;

  // a stage loads when empty or when the next one moves on
  always_comb begin
    load[NUM_STAGES] = out_ready;
    for (int s = NUM_STAGES - 1; s >= 0; s--) begin
      load[s] = !valid_r[s] || load[s+1];
    end
  end

  assign valid_up  = {valid_r[NUM_STAGES-2:0], in_valid};
  assign in_ready  = load[0];
  assign out_valid = valid_r[NUM_STAGES-1];

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    for (genvar k = 0; k < NUM_WIN; k++) begin : g_lane
      localparam int DIG_LSB = DIV_W - DIGIT_W * (s / 2 + 1);
      lane_t prev;

      if (s == 0) begin : g_first
        always_comb begin
          prev      = '0;
          prev.full = in_snap.full[k];
          prev.sum  = in_snap.sum[k];
        end
      end else begin : g_chain
        assign prev = stage_r[s-1][k];
      end

      if (s % 2 == 0) begin : g_mul
        logic [DIV_W-1:0]  dvd;
        logic [PROD_W-1:0] prod;
        always_comb begin
          dvd                     = {prev.sum, {FRAC_W{1'b0}}};
          stage_nxt[s][k]         = prev;
          stage_nxt[s][k].t       = {prev.rem, dvd[DIG_LSB +: DIGIT_W]};
          prod                    = PROD_W'(stage_nxt[s][k].t) * PROD_W'(WIN_RECIP[k]);
          stage_nxt[s][k].quo[DIG_LSB +: DIGIT_W] = prod[RECIP_SHIFT +: DIGIT_W];
        end
      end else begin : g_rem
        logic [T_W:0] qw;
        always_comb begin
          qw = (T_W+1)'(prev.quo[DIG_LSB +: DIGIT_W]) * (T_W+1)'(WIN_LEN[k]);
          stage_nxt[s][k]     = prev;
          stage_nxt[s][k].rem = REM_W'({1'b0, prev.t} - qw);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (load[s]) begin
          valid_r[s] <= valid_up[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NUM_STAGES; s++) begin
      if (load[s]) begin
        stage_r[s] <= stage_nxt[s];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_WIN; k++) begin
      out_quot.full[k] = stage_r[NUM_STAGES-1][k].full;
      out_quot.quo[k]  = stage_r[NUM_STAGES-1][k].quo;
    end
  end

  // the reciprocal step must leave a remainder below the divisor
  for (genvar s = 1; s < NUM_STAGES; s += 2) begin : g_chk
    for (genvar k = 0; k < NUM_WIN; k++) begin : g_lane
      a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_r[s] |-> ((REM_W+1)'(stage_r[s][k].rem) < (REM_W+1)'(WIN_LEN[k])))
        else $error("division remainder out of range");
    end
  end

endmodule

`default_nettype wire

// ===== sv/multi_window_moving_average.sv =====
// ----------------------------------------------------------------------------
// multi_window_moving_average
// Path: an input word, once taken, passes the snapshot register, six divider
//   stages and the output register before its result word is presented.
// Throughput: one word per cycle while out_tready is not held low; the running
//   sums and price shift line update per word; the divider is fully pipelined.
// Reset: synchronous, active low; clears the bar count, the sums and every
//   valid; the price line is not cleared and is never read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_window_moving_average import mwma_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [PRICE_W-1:0]       in_tdata,   // [31:0] close_price
  input  logic [0:0]               in_tuser,   // [0] is_new_bar
  // result channel
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [NUM_WIN*AVG_W-1:0] out_tdata,  // avg_short, avg_medium, avg_long,
                                               // avg_longest, 40 bits each
  output logic [NUM_WIN-1:0]       out_tuser   // short_valid, medium_valid,
                                               // long_valid, longest_valid
);

  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;
  logic  div_valid;
  logic  div_ready;
  quot_t quot;

  logic                     out_valid_r;
  logic [NUM_WIN*AVG_W-1:0] out_data_r, out_data_nxt;
  logic [NUM_WIN-1:0]       out_flags_r;

  // Front end: history line, bar count and running sums. Every accepted
  // word, new bar or revision, produces exactly one snapshot word.
  mwma_history u_history (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_price   (in_tdata),
    .in_new_bar (in_tuser[0]),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  // Constant division: Q32.8 average = floor(sum * 256 / window)
  mwma_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (snap_valid),
    .in_ready  (snap_ready),
    .in_snap   (snap),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_quot  (quot)
  );

  // Output register. Windows not yet full read as zero. Bubbles in the
  // pipeline keep taking words while a result waits here.
  assign div_ready = !out_valid_r || out_tready;

  always_comb begin
    for (int k = 0; k < NUM_WIN; k++) begin
      out_data_nxt[k*AVG_W +: AVG_W] = quot.full[k] ? quot.quo[k][AVG_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ready) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready && div_valid) begin
      out_data_r  <= out_data_nxt;
      out_flags_r <= quot.full;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flags_r;

  // a longer window can only be full when every shorter one is
  for (genvar k = 0; k < NUM_WIN; k++) begin : g_chk
    for (genvar j = 0; j < NUM_WIN; j++) begin : g_pair
      if (WIN_LEN[j] <= WIN_LEN[k]) begin : g_ord
        a_full_order: assert property (@(posedge clk) disable iff (!rst_n)
          (out_valid_r && out_flags_r[k]) |-> out_flags_r[j])
          else $error("window full flags out of order");
      end
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-window moving average. A scoreboard keeps
// its own bar history and running sums, predicts the four averages and valid
// flags for every word taken on the input, and checks each result word in
// order. Both sides idle at random; the receiver also stalls for a long
// stretch to back the block up, and the sender once waits for a full drain.
// ----------------------------------------------------------------------------

module tb_top;
  import mwma_pkg::*;

  localparam int HIST_DEPTH   = 256;
  localparam int ITEMS_TOTAL  = 500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 30;

  typedef enum int {
    PRICE_ANY,
    PRICE_TOP,
    PRICE_LOW,
    PRICE_EDGE
  } price_mode_t;

  // expected result word: averages and valid flags, window 0 in the low bits
  typedef struct packed {
    logic [NUM_WIN-1:0][AVG_W-1:0] avg;
    logic [NUM_WIN-1:0]            valid;
  } avg_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: running-sum predictor plus the queue of pending averages
  // --------------------------------------------------------------------------
  class moving_avg_scoreboard_t;
    logic [PRICE_W-1:0] closes [HIST_DEPTH];
    logic [SUM_W-1:0]   sums [NUM_WIN];
    int unsigned        wr_ptr;
    int unsigned        bars;
    avg_word_t          pending_avgs [$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        appends;
    int unsigned        replaces;
    int unsigned        ignored;
    int unsigned        full_longest;

    function void clear();
      int k;
      for (k = 0; k < HIST_DEPTH; k++) closes[k] = '0;
      for (k = 0; k < NUM_WIN; k++) sums[k] = '0;
      wr_ptr = 0;
      bars = 0;
      pending_avgs.delete();
      errors = 0;
      checked = 0;
      appends = 0;
      replaces = 0;
      ignored = 0;
      full_longest = 0;
    endfunction

    // one word taken on the input: update history and sums, queue the averages
    function void note_bar(input logic [PRICE_W-1:0] price, input logic new_bar);
      avg_word_t   exp_w;
      logic [47:0] scaled;
      int unsigned w;
      int unsigned idx;
      int          k;
      exp_w = '0;
      if (new_bar) begin
        for (k = 0; k < NUM_WIN; k++) begin
          w = WIN_LEN[k];
          if (w >= 1 && w <= HIST_DEPTH) begin
            sums[k] = sums[k] + price;
            if (bars >= w)
              sums[k] = sums[k] - closes[(wr_ptr + HIST_DEPTH - w) % HIST_DEPTH];
          end
        end
        closes[wr_ptr] = price;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
        if (bars < WIN_MAX) bars++;
        appends++;
      end else if (bars != 0) begin
        idx = (wr_ptr + HIST_DEPTH - 1) % HIST_DEPTH;
        for (k = 0; k < NUM_WIN; k++) begin
          w = WIN_LEN[k];
          if (w >= 1 && w <= HIST_DEPTH)
            sums[k] = sums[k] + price - closes[idx];
        end
        closes[idx] = price;
        replaces++;
      end else begin
        // revision with nothing held: state untouched, all-zero word
        ignored++;
      end
      if (new_bar || bars != 0) begin
        for (k = 0; k < NUM_WIN; k++) begin
          w = WIN_LEN[k];
          if (w >= 1 && w <= HIST_DEPTH && bars >= w) begin
            scaled = {sums[k], 8'h00};
            exp_w.avg[k] = AVG_W'(scaled / w);
            exp_w.valid[k] = 1'b1;
          end
        end
      end
      if (exp_w.valid[NUM_WIN-1]) full_longest++;
      pending_avgs = {pending_avgs, exp_w};
    endfunction

    // one result word taken on the output: compare with the oldest prediction
    function void check_word(input logic [NUM_WIN*AVG_W-1:0] tdata,
                             input logic [NUM_WIN-1:0] tuser);
      avg_word_t exp_w;
      int        k;
      if (pending_avgs.size() == 0) begin
        $display("%0t: result word with nothing pending: tdata=%h tuser=%b",
                 $time, tdata, tuser);
        errors++;
      end else begin
        exp_w = pending_avgs.pop_front();
        checked++;
        for (k = 0; k < NUM_WIN; k++) begin
          if (tdata[k*AVG_W +: AVG_W] !== exp_w.avg[k]) begin
            $display("%0t: window %0d average: expected %h, got %h",
                     $time, WIN_LEN[k], exp_w.avg[k], tdata[k*AVG_W +: AVG_W]);
            errors++;
          end
          if (tuser[k] !== exp_w.valid[k]) begin
            $display("%0t: window %0d valid: expected %b, got %b",
                     $time, WIN_LEN[k], exp_w.valid[k], tuser[k]);
            errors++;
          end
        end
      end
    endfunction

    function int unsigned pending();
      return pending_avgs.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [PRICE_W-1:0]       in_tdata = '0;   // [31:0] close_price
  logic [0:0]               in_tuser = '0;   // [0] is_new_bar
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [NUM_WIN*AVG_W-1:0] out_tdata;       // avg_short, avg_medium, avg_long,
                                             // avg_longest, 40 bits each
  logic [NUM_WIN-1:0]       out_tuser;       // short_valid, medium_valid,
                                             // long_valid, longest_valid

  moving_avg_scoreboard_t sb;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned tx_max_gap = 10;
  int unsigned rx_max_gap = 10;
  int unsigned rx_hold_cycles = 0;
  int unsigned input_stalls = 0;

  always #10 clk = ~clk;

  multi_window_moving_average DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_tvalid && !in_tready) input_stalls <= input_stalls + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d words pending", $time, sb.pending());
      $display("multi_window_moving_average test failed");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser);
  end

  // --------------------------------------------------------------------------
  // Drivers: called and left at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_bar(input logic [PRICE_W-1:0] price, input logic new_bar);
    int unsigned gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= price;
    in_tuser  <= new_bar;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
    sb.note_bar(price, new_bar);
    words_sent++;
    @(negedge clk);
  endtask

  // receiver: random gap per word, or a long hold when one is requested
  task automatic take_results();
    int unsigned gap;
    forever begin
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, rx_max_gap);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      @(negedge clk);
    end
  endtask

  function automatic logic [PRICE_W-1:0] pick_close(input price_mode_t mode);
    logic [PRICE_W-1:0] p;
    case (mode)
      PRICE_TOP: begin
        p = '1 - $urandom_range(0, 3);
      end
      PRICE_LOW: begin
        p = $urandom_range(0, 255);
      end
      PRICE_EDGE: begin
        case ($urandom_range(0, 4))
          0:       p = '0;
          1:       p = '1;
          2:       p = 32'h8000_0000;
          3:       p = 32'h7fff_ffff;
          default: p = 32'h0000_0001;
        endcase
      end
      default: begin
        p = $urandom;
      end
    endcase
    return p;
  endfunction

  initial begin
    wait (rst_n === 1'b1);
    @(negedge clk);
    take_results();
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    price_mode_t mode;
    int unsigned seg_len;
    int unsigned append_pct;
    int unsigned wait_cycles;
    bit          did_top_run;
    bit          did_hold;
    bit          did_drain;

    sb = new;
    sb.clear();
    did_top_run = 0;
    did_hold = 0;
    did_drain = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: revisions while empty, extremes, a revision of a lone bar,
    // then enough bars to fill the short window and revise it
    send_bar('1, 1'b0);
    send_bar('0, 1'b0);
    send_bar('1, 1'b1);
    send_bar('0, 1'b0);
    send_bar('1, 1'b0);
    send_bar('0, 1'b1);
    send_bar('1, 1'b1);
    send_bar(32'h0000_0001, 1'b1);
    send_bar(32'h8000_0000, 1'b1);
    send_bar('1, 1'b1);
    send_bar(32'h7fff_ffff, 1'b0);
    send_bar('0, 1'b0);
    send_bar('1, 1'b0);
    repeat (8) send_bar('1, 1'b1);
    send_bar('0, 1'b1);
    send_bar('1, 1'b0);

    // random segments, each with its own price style, revision rate and idling
    while (words_sent < ITEMS_TOTAL) begin
      if (!did_top_run && words_sent > 80) begin
        // full-scale closes long enough to fill the longest window at its peak
        did_top_run = 1;
        repeat (WIN_MAX + 5) send_bar(pick_close(PRICE_TOP), 1'b1);
      end
      if (!did_hold && words_sent > 320) begin
        // receiver holds off while words keep coming: the pipe fills and stalls
        did_hold = 1;
        tx_max_gap = 0;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (30) send_bar(pick_close(PRICE_ANY), $urandom_range(0, 3) != 0);
      end
      if (!did_drain && words_sent > 400) begin
        // sender pauses until every pending word has come back
        did_drain = 1;
        in_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      seg_len = $urandom_range(1, 40);
      mode = price_mode_t'($urandom_range(0, 3));
      append_pct = ($urandom_range(0, 3) == 0) ? 40 : 90;
      tx_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 10;
      rx_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 10;
      repeat (seg_len) send_bar(pick_close(mode), $urandom_range(0, 99) < append_pct);
    end
    in_tvalid <= 1'b0;

    // drain, then a short tail to catch stray words
    while (sb.pending() != 0) @(negedge clk);
    wait_cycles = TAIL_CYCLES;
    repeat (wait_cycles) @(posedge clk);

    $display("Covered %0d new bars, %0d revisions, %0d revisions on an empty history;",
             sb.appends, sb.replaces, sb.ignored);
    $display("%0d words checked, %0d with the longest window full, %0d input stall cycles.",
             sb.checked, sb.full_longest, input_stalls);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("multi_window_moving_average test passed");
    end else begin
      $display("multi_window_moving_average test failed");
    end
    $finish;
  end

endmodule

// ===== multi_window_moving_average.f =====
sv/mwma_pkg.sv
sv/mwma_history.sv
sv/mwma_divider.sv
sv/multi_window_moving_average.sv
verif/tb_top.sv
